@@ rtl/core/tmmc_pkg.sv @@
// Package: sizes, codes and shared types of the collection matrix engine.
`default_nettype none
package tmmc_pkg;

	localparam int MAX_MACROSTATES    = 1024;
	localparam int MAX_SUBSTATES      = 64;
	localparam int PROB_FRACTION_BITS = 16;

	localparam int DEPTH = 3 * MAX_MACROSTATES;
	localparam int AW    = $clog2(DEPTH);
	localparam int KW    = $clog2(MAX_MACROSTATES);
	localparam int CW    = 48;
	localparam int VW    = 32;
	localparam int PW    = PROB_FRACTION_BITS + 1;
	localparam int NW    = 10;
	localparam int NEW   = 12;
	localparam int MW    = 6;
	localparam int SUBW  = 7;
	localparam int SSW   = 32;
	localparam int RIW   = 2;

	localparam logic [PW-1:0] PROB_ONE = PW'(1) << PROB_FRACTION_BITS;

	typedef enum logic [1:0] {
		CMD_RECORD = 2'd0,
		CMD_READ   = 2'd1,
		CMD_CHECK  = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_OOB     = 2'd1,
		ST_ILLEGAL = 2'd2,
		ST_CFG     = 2'd3
	} status_t;

	typedef enum logic [RIW-1:0] {
		REG_LOWER = 2'd0,
		REG_UPPER = 2'd1,
		REG_SUBS  = 2'd2,
		REG_SWEEP = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		BK_INIT,
		BK_IDLE,
		BK_RD_DONE,
		BK_WR1,
		BK_WR2,
		BK_CHK,
		BK_CHK_END,
		BK_CLR,
		BK_RESP
	} bk_state_t;

	typedef struct packed {
		logic [NW-1:0]   lower;
		logic [NW-1:0]   upper;
		logic [SUBW-1:0] subs;
		logic [SSW-1:0]  sweep;
	} cfg_t;

	// one classified command waiting for the back end
	typedef struct packed {
		cmd_t            cmd;
		status_t         status;
		logic [AW-1:0]   addr;
		logic [AW-1:0]   stay;
		logic [PW-1:0]   pa;
		logic            vinc;
		logic [KW-1:0]   last;
	} entry_t;

	typedef struct packed {
		logic init_busy;
	} bk_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/tmmc_ifs.sv @@
// Channel interfaces: command request, result and configuration write.
`default_nettype none
interface tmmc_req_if;
	import tmmc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [1:0]            command;
	logic [NW-1:0]         count_start;
	logic signed [NEW-1:0] count_end;
	logic [MW-1:0]         substate_start;
	logic [MW-1:0]         substate_end;
	logic [PW-1:0]         accept_prob;
	modport source (output valid, command, count_start, count_end, substate_start,
		substate_end, accept_prob, input ready);
	modport sink (input valid, command, count_start, count_end, substate_start,
		substate_end, accept_prob, output ready);
endinterface

interface tmmc_rsp_if;
	import tmmc_pkg::*;
	logic          valid;
	logic          ready;
	logic [1:0]    status;
	logic          fully_visited;
	logic [CW-1:0] collection_value;
	logic [VW-1:0] visit_count;
	logic [VW-1:0] sweeps_done;
	modport source (output valid, status, fully_visited, collection_value, visit_count,
		sweeps_done, input ready);
	modport sink (input valid, status, fully_visited, collection_value, visit_count,
		sweeps_done, output ready);
endinterface

interface tmmc_cfg_if;
	import tmmc_pkg::*;
	logic           valid;
	logic           ready;
	logic [RIW-1:0] index;
	logic [SSW-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/tmmc_front.sv @@
// Front end: takes command beats, checks bounds and moves, forms table addresses.
`default_nettype none
module tmmc_front (
	tmmc_req_if.sink         req,
	input  tmmc_pkg::cfg_t   cfg,
	input  tmmc_pkg::bk_stat_t bk_stat,
	output logic             push_valid,
	input  logic             push_ready,
	output tmmc_pkg::entry_t push_data
);
	import tmmc_pkg::*;

	logic [NW:0]          span_n;
	logic [17:0]          span;
	logic                 cfg_ok;
	logic signed [12:0]   ns13, ne13, lo13, hi13;
	logic                 oob;
	logic signed [MW:0]   dm;
	logic [MW-1:0]        m_last;
	logic                 illegal;
	logic [1:0]           y;
	logic [NW-1:0]        off;
	logic [16:0]          prod;
	logic [18:0]          base;
	logic                 range_bad;
	logic [16:0]          last_w;
	logic [PW-1:0]        pa_c;
	cmd_t                 cmd;

	assign cmd    = cmd_t'(req.command);
	assign span_n = {1'b0, cfg.upper} - {1'b0, cfg.lower} + (NW+1)'(1);
	assign span   = 18'(span_n) * 18'(cfg.subs);
	assign cfg_ok = (cfg.lower <= cfg.upper) && (cfg.subs != '0)
		&& (cfg.subs <= SUBW'(MAX_SUBSTATES)) && (cfg.sweep != '0)
		&& (span <= 18'(MAX_MACROSTATES));

	assign ns13 = $signed({3'b000, req.count_start});
	assign ne13 = $signed({req.count_end[NEW-1], req.count_end});
	assign lo13 = $signed({3'b000, cfg.lower});
	assign hi13 = $signed({3'b000, cfg.upper});

	assign oob = (ns13 > hi13) || (ns13 < lo13) || (ne13 > hi13 + 13'sd1)
		|| (ne13 < lo13 - 13'sd1) || ({1'b0, req.substate_start} >= cfg.subs)
		|| ({1'b0, req.substate_end} >= cfg.subs);

	assign dm     = $signed({1'b0, req.substate_end}) - $signed({1'b0, req.substate_start});
	assign m_last = MW'(cfg.subs - SUBW'(1));

	always_comb begin
		illegal = 1'b0;
		y       = 2'd0;
		if (ne13 == ns13) begin
			if (dm == 7'sd0) y = 2'd0;
			else if (dm == 7'sd1) y = 2'd1;
			else if (dm == -7'sd1) y = 2'd2;
			else illegal = 1'b1;
		end else if (ne13 == ns13 + 13'sd1) begin
			y = 2'd1;
			illegal = !(req.substate_start == m_last && req.substate_end == '0);
		end else if (ne13 == ns13 - 13'sd1) begin
			y = 2'd2;
			illegal = !(req.substate_start == '0 && req.substate_end == m_last);
		end else begin
			illegal = 1'b1;
		end
	end

	assign off       = req.count_start - cfg.lower;
	assign prod      = 17'(off) * 17'(cfg.subs) + 17'(req.substate_start);
	assign base      = 19'(prod) * 19'd3;
	assign range_bad = (base + 19'd2) >= 19'(DEPTH);
	assign last_w    = 17'(cfg.upper - cfg.lower) * 17'(cfg.subs);
	assign pa_c      = (req.accept_prob > PROB_ONE) ? PROB_ONE : req.accept_prob;

	always_comb begin
		push_data.cmd  = cmd;
		push_data.addr = AW'(base + 19'(y));
		push_data.stay = AW'(base);
		push_data.pa   = pa_c;
		push_data.vinc = (pa_c != '0) || (req.count_start == '0 && req.count_end == '0);
		push_data.last = KW'(last_w);
		case (cmd)
			CMD_RECORD, CMD_READ: begin
				if (!cfg_ok) push_data.status = ST_CFG;
				else if (oob) push_data.status = ST_OOB;
				else if (illegal) push_data.status = ST_ILLEGAL;
				else if (range_bad) push_data.status = ST_OOB;
				else push_data.status = ST_OK;
			end
			CMD_CHECK: push_data.status = cfg_ok ? ST_OK : ST_CFG;
			default:   push_data.status = ST_OK;
		endcase
	end

	assign req.ready  = push_ready && !bk_stat.init_busy;
	assign push_valid = req.valid && !bk_stat.init_busy;

endmodule
`default_nettype wire

@@ rtl/core/tmmc_queue.sv @@
// Two-entry queue of classified commands between front and back end.
`default_nettype none
module tmmc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  tmmc_pkg::entry_t push_data,
	output logic             pop_valid,
	input  logic             pop,
	output tmmc_pkg::entry_t pop_data
);
	import tmmc_pkg::*;

	localparam int QD = 2;

	entry_t      slot_q [QD];
	logic        wr_q, rd_q;
	logic [1:0]  cnt_q;
	logic        do_push;

	assign push_ready = (cnt_q != 2'(QD));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(pop);
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/tmmc_back.sv @@
// Back end: collection and visit memories, record/read/check/clear sequencer.
`default_nettype none
module tmmc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  tmmc_pkg::cfg_t     cfg,
	input  logic               q_valid,
	output logic               q_pop,
	input  tmmc_pkg::entry_t   q_data,
	output tmmc_pkg::bk_stat_t bk_stat,
	tmmc_rsp_if.source         rsp
);
	import tmmc_pkg::*;

	logic [CW-1:0] coll_mem [DEPTH];
	logic [VW-1:0] vis_mem  [DEPTH];
	logic [CW-1:0] c_rd_q;
	logic [VW-1:0] v_rd_q;

	logic          c_we, v_we;
	logic [AW-1:0] c_wa, c_ra, v_wa, v_ra;
	logic [CW-1:0] c_wd;
	logic [VW-1:0] v_wd;

	bk_state_t     state_q, state_d;
	entry_t        ent_q;
	logic [AW-1:0] e_q;
	logic [KW-1:0] k_q;
	logic [1:0]    j_q;
	logic          pend_q, fail_q, need;
	logic          seq_end;

	status_t       res_status_q;
	logic          res_full_q;
	logic [CW-1:0] res_cval_q;
	logic [VW-1:0] res_vval_q;
	logic [VW-1:0] sweep_q;

	logic          out_valid_q;
	logic          can_emit;
	logic [CW:0]   c_sum;
	logic [CW-1:0] c_add, c_sat;
	logic [VW-1:0] v_new;
	logic          short_vis;

	always_ff @(posedge clk) begin
		if (c_we) coll_mem[c_wa] <= c_wd;
		c_rd_q <= coll_mem[c_ra];
	end

	always_ff @(posedge clk) begin
		if (v_we) vis_mem[v_wa] <= v_wd;
		v_rd_q <= vis_mem[v_ra];
	end

	assign can_emit  = !out_valid_q || rsp.ready;
	assign seq_end   = (e_q == AW'(DEPTH - 1));
	assign short_vis = v_rd_q < cfg.sweep;

	// stay move: pa plus 1-pa on one entry is one add of 1.0
	always_comb begin
		if (state_q == BK_WR2) c_add = CW'(PROB_ONE - ent_q.pa);
		else if (ent_q.addr == ent_q.stay) c_add = CW'(PROB_ONE);
		else c_add = CW'(ent_q.pa);
	end
	assign c_sum = {1'b0, c_rd_q} + {1'b0, c_add};
	assign c_sat = c_sum[CW] ? '1 : c_sum[CW-1:0];
	assign v_new = (ent_q.vinc && v_rd_q != '1) ? v_rd_q + VW'(1) : v_rd_q;

	always_comb begin
		case (j_q)
			2'd0:    need = 1'b1;
			2'd1:    need = (k_q == '0) || (k_q != ent_q.last);
			default: need = (k_q != '0);
		endcase
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		c_we    = 1'b0;
		v_we    = 1'b0;
		c_wa    = ent_q.addr;
		v_wa    = ent_q.addr;
		c_wd    = c_sat;
		v_wd    = v_new;
		c_ra    = q_data.addr;
		v_ra    = q_data.addr;
		case (state_q)
			BK_INIT: begin
				c_we = 1'b1;
				v_we = 1'b1;
				c_wa = e_q;
				v_wa = e_q;
				c_wd = '0;
				v_wd = '0;
				if (seq_end) state_d = BK_IDLE;
			end
			BK_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					case (q_data.cmd)
						CMD_RECORD: state_d = (q_data.status == ST_OK) ? BK_WR1 : BK_RESP;
						CMD_READ:   state_d = (q_data.status == ST_OK) ? BK_RD_DONE : BK_RESP;
						CMD_CHECK:  state_d = (q_data.status == ST_OK) ? BK_CHK : BK_RESP;
						default:    state_d = BK_CLR;
					endcase
				end
			end
			BK_RD_DONE: state_d = BK_RESP;
			BK_WR1: begin
				c_we = 1'b1;
				v_we = 1'b1;
				c_ra = ent_q.stay;
				state_d = (ent_q.addr != ent_q.stay) ? BK_WR2 : BK_RESP;
			end
			BK_WR2: begin
				c_we = 1'b1;
				c_wa = ent_q.stay;
				state_d = BK_RESP;
			end
			BK_CHK: begin
				v_ra = e_q;
				if (k_q == ent_q.last && j_q == 2'd2) state_d = BK_CHK_END;
			end
			BK_CHK_END: state_d = BK_RESP;
			BK_CLR: begin
				v_we = 1'b1;
				v_wa = e_q;
				v_wd = '0;
				if (seq_end) state_d = BK_RESP;
			end
			BK_RESP: begin
				if (can_emit) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BK_INIT;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q         <= '0;
			k_q         <= '0;
			j_q         <= '0;
			pend_q      <= 1'b0;
			fail_q      <= 1'b0;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == BK_RESP && can_emit) out_valid_q <= 1'b1;
			else if (out_valid_q && rsp.ready) out_valid_q <= 1'b0;
			case (state_q)
				BK_INIT: e_q <= seq_end ? '0 : e_q + AW'(1);
				BK_IDLE: begin
					e_q    <= '0;
					k_q    <= '0;
					j_q    <= '0;
					pend_q <= 1'b0;
					fail_q <= 1'b0;
				end
				BK_CHK: begin
					pend_q <= need;
					if (pend_q && short_vis) fail_q <= 1'b1;
					e_q <= e_q + AW'(1);
					if (j_q == 2'd2) begin
						j_q <= '0;
						k_q <= k_q + KW'(1);
					end else begin
						j_q <= j_q + 2'd1;
					end
				end
				BK_CLR: begin
					e_q <= e_q + AW'(1);
					if (seq_end && sweep_q != '1) sweep_q <= sweep_q + VW'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				ent_q        <= q_data;
				res_status_q <= q_data.status;
				res_full_q   <= 1'b0;
				res_cval_q   <= '0;
				res_vval_q   <= '0;
			end
			BK_RD_DONE: begin
				res_cval_q <= c_rd_q;
				res_vval_q <= v_rd_q;
			end
			BK_WR1: begin
				res_cval_q <= c_sat;
				res_vval_q <= v_new;
			end
			BK_CHK_END: res_full_q <= !(fail_q || (pend_q && short_vis));
			BK_RESP: begin
				if (can_emit) begin
					rsp.status           <= res_status_q;
					rsp.fully_visited    <= res_full_q;
					rsp.collection_value <= res_cval_q;
					rsp.visit_count      <= res_vval_q;
					rsp.sweeps_done      <= sweep_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid         = out_valid_q;
	assign bk_stat.init_busy = (state_q == BK_INIT);

endmodule
`default_nettype wire

@@ rtl/core/tmmc_collection_matrix_engine_unit.sv @@
// Top level: configuration registers, front end, command queue and back end.
// A record of a stay move writes one table entry, any other record two; a check walks the visit
// memory up to the last macrostate of the window, and a clear sweeps the whole visit memory.
// One command is carried out at a time; the two-entry queue lets up to two more
// request beats be taken while the back end works and a result beat waits.
// Reset is asynchronous, active low; afterwards a clearing pass over every entry
// zeroes both tables, during which no request beat is taken (config still is).
`default_nettype none
module tmmc_collection_matrix_engine_unit (
	input  logic  clk,
	input  logic  arst_n,
	tmmc_req_if.sink   req,
	tmmc_cfg_if.sink   cfg,
	tmmc_rsp_if.source rsp
);
	import tmmc_pkg::*;

	cfg_t     cfg_q;
	bk_stat_t bk_stat;
	logic     push_valid, push_ready, q_valid, q_pop;
	entry_t   push_data, q_data;

	// config writes are always taken; indexes beyond the list are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lower <= '0;
			cfg_q.upper <= '0;
			cfg_q.subs  <= SUBW'(1);
			cfg_q.sweep <= SSW'(1);
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_LOWER: cfg_q.lower <= cfg.data[NW-1:0];
				REG_UPPER: cfg_q.upper <= cfg.data[NW-1:0];
				REG_SUBS:  cfg_q.subs  <= cfg.data[SUBW-1:0];
				REG_SWEEP: cfg_q.sweep <= cfg.data;
				default: ;
			endcase
		end
	end

	// classify each beat as it arrives
	tmmc_front u_front (
		.req        (req),
		.cfg        (cfg_q),
		.bk_stat    (bk_stat),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	tmmc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_data   (q_data)
	);

	// memories and the per-command sequencer
	tmmc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_data  (q_data),
		.bk_stat (bk_stat),
		.rsp     (rsp)
	);

endmodule
`default_nettype wire

@@ rtl/core/tmmc_checker.sv @@
// Port-level checker for the engine and its bind to the top level.
`default_nettype none
module tmmc_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_ready,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input logic [1:0]            rsp_status,
	input logic                  rsp_full,
	input logic [tmmc_pkg::CW-1:0] rsp_cval,
	input logic [tmmc_pkg::VW-1:0] rsp_vval,
	input logic [tmmc_pkg::VW-1:0] rsp_sweeps
);
	import tmmc_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cval) && $stable(rsp_sweeps))
		else $error("result beat changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_OK |-> rsp_cval == '0 && rsp_vval == '0)
		else $error("failed command carries table data");

	a_full_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_full |-> rsp_status == ST_OK && rsp_cval == '0)
		else $error("fully visited with bad status or data");

	a_init: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !req_ready && !rsp_valid)
		else $error("beat taken during clearing pass");

endmodule

bind tmmc_collection_matrix_engine_unit tmmc_checker u_tmmc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_full   (rsp.fully_visited),
	.rsp_cval   (rsp.collection_value),
	.rsp_vval   (rsp.visit_count),
	.rsp_sweeps (rsp.sweeps_done)
);
`default_nettype wire

@@ tb/tmmc_collection_matrix_engine_unit_tb.sv @@
// Self-checking testbench of the collection matrix engine: directed table, then random phases.
`timescale 1ns / 100ps
`default_nettype none
module tmmc_collection_matrix_engine_unit_tb;
	import tmmc_pkg::*;

	// generous ceiling; the slowest commands are clear and the full-window check
	localparam int CYCLE_LIMIT = 12000000;
	localparam int PHASE_ITEMS = 55;
	localparam logic [CW-1:0] COLL_SAT = {CW{1'b1}};
	localparam logic [VW-1:0] VISIT_SAT = {VW{1'b1}};

	typedef struct packed {
		logic [1:0]    status;
		logic          full;
		logic [CW-1:0] cval;
		logic [VW-1:0] vval;
		logic [VW-1:0] sweeps;
	} result_t;

	// one row of the directed table: either a register write or a command beat
	typedef struct {
		bit            is_reg;
		bit            typed;
		logic [1:0]    op;
		logic [NW-1:0] ns;
		logic [NEW-1:0] ne;
		logic [MW-1:0] ms;
		logic [MW-1:0] me;
		logic [31:0]   data;
		result_t       res;
	} row_t;

	logic clk;
	logic arst_n;

	tmmc_req_if req_ch ();
	tmmc_cfg_if cfg_ch ();
	tmmc_rsp_if rsp_ch ();

	tmmc_collection_matrix_engine_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.cfg    (cfg_ch),
		.rsp    (rsp_ch)
	);

	// shadow state of the block
	logic [CW-1:0] coll_mem [DEPTH];
	logic [VW-1:0] visit_mem [DEPTH];
	logic [VW-1:0] sweep_cnt;
	logic [NW-1:0] win_lo, win_hi;
	logic [SUBW-1:0] sub_total;
	logic [SSW-1:0] sweep_need;

	result_t pending_results [$];
	row_t    dir_rows [$];

	int errors = 0, cycles = 0, n_records = 0, n_full = 0, n_clears = 0, n_rejects = 0;
	int burst_left = 0, stall_pct = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("MISMATCH %s: got %0h, want %0h (cycle %0d)", what, got, want, cycles);
		errors++;
	endtask

	// ---------------- predictor ----------------
	function automatic bit window_ok();
		if (win_lo > win_hi) return 0;
		if (sub_total < 1 || sub_total > MAX_SUBSTATES) return 0;
		if (sweep_need == 0) return 0;
		return (int'(win_hi) - int'(win_lo) + 1) * int'(sub_total) <= MAX_MACROSTATES;
	endfunction

	// classify a move, give the transition and stay entries
	function automatic logic [1:0] locate_move(input int ns, ne, ms, me,
			output int addr, output int stay);
		int lo, hi, mt, y, base;
		lo = int'(win_lo); hi = int'(win_hi); mt = int'(sub_total);
		addr = 0; stay = 0; y = 0;
		if (!window_ok()) return ST_CFG;
		if (ns > hi || ns < lo || ne > hi + 1 || ne < lo - 1 || ms > mt - 1 || me > mt - 1)
			return ST_OOB;
		if (ns == ne) begin
			if (me == ms) y = 0;
			else if (me - ms == 1) y = 1;
			else if (me - ms == -1) y = 2;
			else return ST_ILLEGAL;
		end else if (ne == ns + 1) begin
			if (ms != mt - 1 || me != 0) return ST_ILLEGAL;
			y = 1;
		end else if (ne == ns - 1) begin
			if (ms != 0 || me != mt - 1) return ST_ILLEGAL;
			y = 2;
		end else begin
			return ST_ILLEGAL;
		end
		base = 3 * ((ns - lo) * mt + ms);
		if (base + 2 >= DEPTH) return ST_OOB;
		addr = base + y;
		stay = base;
		return ST_OK;
	endfunction

	function automatic void coll_accumulate(input int a, input logic [CW-1:0] v);
		if (coll_mem[a] > COLL_SAT - v) coll_mem[a] = COLL_SAT;
		else coll_mem[a] = coll_mem[a] + v;
	endfunction

	function automatic logic sweep_complete();
		int total, b;
		total = (int'(win_hi) - int'(win_lo)) * int'(sub_total) + 1;
		for (int k = 0; k < total; k++) begin
			b = 3 * k;
			if (visit_mem[b] < sweep_need) return 0;
			if (k == 0) begin
				if (visit_mem[b+1] < sweep_need) return 0;
			end else if (k == total - 1) begin
				if (visit_mem[b+2] < sweep_need) return 0;
			end else if (visit_mem[b+1] < sweep_need || visit_mem[b+2] < sweep_need) begin
				return 0;
			end
		end
		return 1;
	endfunction

	function automatic result_t predict_command(input logic [1:0] op, input logic [NW-1:0] ns,
			input logic [NEW-1:0] ne, input logic [MW-1:0] ms, input logic [MW-1:0] me,
			input logic [PW-1:0] pa_raw);
		result_t r;
		int addr, stay, ne_i;
		logic [PW-1:0] pa;
		r = '0;
		pa = (pa_raw > PROB_ONE) ? PROB_ONE : pa_raw;
		ne_i = int'($signed(ne));
		case (op)
			CMD_RECORD, CMD_READ: begin
				r.status = locate_move(int'(ns), ne_i, int'(ms), int'(me), addr, stay);
				if (r.status == ST_OK) begin
					if (op == CMD_RECORD) begin
						coll_accumulate(addr, CW'(pa));
						coll_accumulate(stay, CW'(PROB_ONE - pa));
						if ((pa > 0 || (ns == 0 && ne_i == 0)) && visit_mem[addr] < VISIT_SAT)
							visit_mem[addr]++;
						n_records++;
					end
					r.cval = coll_mem[addr];
					r.vval = visit_mem[addr];
				end else begin
					n_rejects++;
				end
			end
			CMD_CHECK: begin
				if (!window_ok()) r.status = ST_CFG;
				else r.full = sweep_complete();
				if (r.full) n_full++;
			end
			default: begin
				foreach (visit_mem[i]) visit_mem[i] = '0;
				if (sweep_cnt < VISIT_SAT) sweep_cnt++;
				n_clears++;
			end
		endcase
		r.sweeps = sweep_cnt;
		return r;
	endfunction

	// ---------------- driving ----------------
	task automatic send_command(input logic [1:0] op, input logic [NW-1:0] ns,
			input logic [NEW-1:0] ne, input logic [MW-1:0] ms, input logic [MW-1:0] me,
			input logic [PW-1:0] pa, input bit typed, input result_t typed_res);
		result_t r;
		@(negedge clk);
		req_ch.valid = 1'b1;
		req_ch.command = op;
		req_ch.count_start = ns;
		req_ch.count_end = ne;
		req_ch.substate_start = ms;
		req_ch.substate_end = me;
		req_ch.accept_prob = pa;
		do @(posedge clk); while (!req_ch.ready);
		// beat taken: update shadow state, queue what must come back
		r = predict_command(op, ns, ne, ms, me, pa);
		pending_results.push_back(typed ? typed_res : r);
	endtask

	// sender side of bursts
	task automatic sender_pace();
		if (burst_left == 0) begin
			@(negedge clk);
			req_ch.valid = 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
	endtask

	task automatic drain();
		@(negedge clk);
		req_ch.valid = 1'b0;
		wait (pending_results.size() == 0);
		repeat (8) @(negedge clk);
	endtask

	// registers change only with nothing in flight
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		drain();
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = value;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_LOWER: win_lo = value[NW-1:0];
			REG_UPPER: win_hi = value[NW-1:0];
			REG_SUBS:  sub_total = value[SUBW-1:0];
			default:   sweep_need = value;
		endcase
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic set_window(input logic [31:0] lo, hi, subs, sweep);
		write_reg(REG_LOWER, lo);
		write_reg(REG_UPPER, hi);
		write_reg(REG_SUBS, subs);
		write_reg(REG_SWEEP, sweep);
	endtask

	function automatic row_t cmd_row(input logic [1:0] op, input int ns, ne, ms, me,
			input int pa);
		row_t r;
		r = '{default: '0};
		r.op = op; r.ns = NW'(ns); r.ne = NEW'(ne); r.ms = MW'(ms); r.me = MW'(me);
		r.data = pa;
		return r;
	endfunction

	function automatic row_t typed_row(input logic [1:0] op, input int ns, ne, ms, me,
			input int pa, input logic [1:0] st, input logic [CW-1:0] cv,
			input logic [VW-1:0] vv, input logic [VW-1:0] sw);
		row_t r;
		r = cmd_row(op, ns, ne, ms, me, pa);
		r.typed = 1;
		r.res = '{status: st, full: 1'b0, cval: cv, vval: vv, sweeps: sw};
		return r;
	endfunction

	function automatic row_t reg_row(input reg_idx_t idx, input logic [31:0] value);
		row_t r;
		r = '{default: '0};
		r.is_reg = 1; r.op = idx; r.data = value;
		return r;
	endfunction

	// random beat; mostly legal moves inside the current window
	task automatic random_command();
		logic [1:0] op;
		int lo, hi, mt, ns, ne, ms, me, pa, pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) op = CMD_RECORD;
		else if (pick < 85) op = CMD_READ;
		else if (pick < 96) op = CMD_CHECK;
		else op = CMD_CLEAR;
		case ($urandom_range(0, 3))
			0: pa = 0;
			1: pa = 1 << PROB_FRACTION_BITS;
			2: pa = $urandom_range(0, 1 << PROB_FRACTION_BITS);
			default: pa = $urandom_range(0, (1 << PW) - 1);
		endcase
		if (!window_ok() || $urandom_range(0, 9) == 0) begin
			// noise: every field bit free
			ns = $urandom_range(0, 1023); ne = $urandom_range(0, 4095);
			ms = $urandom_range(0, 63); me = $urandom_range(0, 63);
		end else begin
			lo = int'(win_lo); hi = int'(win_hi); mt = int'(sub_total);
			ns = $urandom_range(lo, hi);
			ms = $urandom_range(0, mt - 1);
			ne = ns; me = ms;
			case ($urandom_range(0, 5))
				0: ;
				1: me = (ms + 1) % 64;
				2: me = (ms + 63) % 64;
				3: begin ms = mt - 1; me = 0; ne = ns + 1; end
				4: begin ms = 0; me = mt - 1; ne = ns - 1; end
				default: begin
					me = $urandom_range(0, mt - 1);
					ne = ns + $urandom_range(0, 4) - 2;
				end
			endcase
		end
		sender_pace();
		send_command(op, NW'(ns), NEW'(ne), MW'(ms), MW'(me), PW'(pa), 0, '0);
	endtask

	// ---------------- receiver and checking ----------------
	always @(negedge clk) begin
		if (cycles % 256 == 0) begin
			case ($urandom_range(0, 2))
				0: stall_pct = 0;
				1: stall_pct = 30;
				default: stall_pct = 75;
			endcase
		end
		rsp_ch.ready = ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		result_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, pending_results.size());
			$display("Regression FAIL");
			$finish;
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				report("unexpected result beat", rsp_ch.status, 0);
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.status !== want.status) report("status", rsp_ch.status, want.status);
				if (rsp_ch.fully_visited !== want.full)
					report("fully_visited", rsp_ch.fully_visited, want.full);
				if (rsp_ch.collection_value !== want.cval)
					report("collection_value", rsp_ch.collection_value, want.cval);
				if (rsp_ch.visit_count !== want.vval)
					report("visit_count", rsp_ch.visit_count, want.vval);
				if (rsp_ch.sweeps_done !== want.sweeps)
					report("sweeps_done", rsp_ch.sweeps_done, want.sweeps);
			end
		end
	end

	// ---------------- main sequence ----------------
	initial begin
		int lo, hi, subs;
		row_t row;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_RECORD;
		req_ch.count_start = '0;
		req_ch.count_end = '0;
		req_ch.substate_start = '0;
		req_ch.substate_end = '0;
		req_ch.accept_prob = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_LOWER;
		cfg_ch.data = '0;
		foreach (coll_mem[i]) coll_mem[i] = '0;
		foreach (visit_mem[i]) visit_mem[i] = '0;
		sweep_cnt = '0;
		win_lo = 0; win_hi = 0; sub_total = 1; sweep_need = 1;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset window is N=0 with one substate
		dir_rows.push_back(typed_row(CMD_READ, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0));
		// 0 -> 0 stay: full 1.0 on the stay entry, visit bumped even with pa = 0
		dir_rows.push_back(typed_row(CMD_RECORD, 0, 0, 0, 0, 0, ST_OK, 65536, 1, 0));
		dir_rows.push_back(cmd_row(CMD_RECORD, 0, 1, 0, 0, 'h1FFFF));   // pa clamps to 1.0
		dir_rows.push_back(cmd_row(CMD_RECORD, 0, -1, 0, 0, 100));
		dir_rows.push_back(typed_row(CMD_RECORD, 0, 2, 0, 0, 5, ST_OOB, 0, 0, 0));
		dir_rows.push_back(typed_row(CMD_RECORD, 1, 1, 0, 0, 5, ST_OOB, 0, 0, 0));
		dir_rows.push_back(typed_row(CMD_READ, 0, 0, 1, 0, 5, ST_OOB, 0, 0, 0));
		dir_rows.push_back(cmd_row(CMD_CHECK, 0, 0, 0, 0, 0));
		dir_rows.push_back(typed_row(CMD_CLEAR, 1023, -1, 63, 63, 'h1FFFF, ST_OK, 0, 0, 1));
		dir_rows.push_back(cmd_row(CMD_CHECK, 0, 0, 0, 0, 0));
		dir_rows.push_back(reg_row(REG_LOWER, 2));
		dir_rows.push_back(reg_row(REG_UPPER, 5));
		dir_rows.push_back(reg_row(REG_SUBS, 3));
		dir_rows.push_back(reg_row(REG_SWEEP, 2));
		dir_rows.push_back(cmd_row(CMD_RECORD, 3, 3, 0, 1, 30000));
		dir_rows.push_back(cmd_row(CMD_RECORD, 3, 3, 1, 0, 0));
		dir_rows.push_back(typed_row(CMD_RECORD, 3, 5, 0, 0, 9, ST_ILLEGAL, 0, 0, 1));
		dir_rows.push_back(typed_row(CMD_RECORD, 3, 3, 0, 2, 9, ST_ILLEGAL, 0, 0, 1));
		// crossing up must leave from the last substate
		dir_rows.push_back(typed_row(CMD_RECORD, 3, 4, 1, 0, 9, ST_ILLEGAL, 0, 0, 1));
		dir_rows.push_back(cmd_row(CMD_RECORD, 3, 4, 2, 0, 65535));
		dir_rows.push_back(cmd_row(CMD_RECORD, 5, 6, 2, 0, 40000));
		dir_rows.push_back(cmd_row(CMD_READ, 2, 1, 0, 2, 0));
		dir_rows.push_back(typed_row(CMD_RECORD, 5, 7, 2, 0, 9, ST_OOB, 0, 0, 1));
		// zero substates: window rejected, clear still counts
		dir_rows.push_back(reg_row(REG_SUBS, 0));
		dir_rows.push_back(typed_row(CMD_RECORD, 2, 2, 0, 0, 9, ST_CFG, 0, 0, 1));
		dir_rows.push_back(typed_row(CMD_CHECK, 2, 2, 0, 0, 9, ST_CFG, 0, 0, 1));
		dir_rows.push_back(typed_row(CMD_CLEAR, 0, 0, 0, 0, 0, ST_OK, 0, 0, 2));

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.is_reg) write_reg(reg_idx_t'(row.op), row.data);
			else send_command(row.op, row.ns, row.ne, row.ms, row.me, row.data[PW-1:0],
				row.typed, row.res);
		end

		// random phases: extremes, invalid windows, then random legal windows
		for (int ph = 0; ph < 14; ph++) begin
			case (ph)
				0:  set_window(0, 9, 4, 2);
				1:  set_window(100, 115, 64, 1);            // exactly the full table
				2:  set_window(0, 1, 2, 1);                 // tiny window, sweeps complete
				3:  set_window(1000, 1023, 1, 3);
				4:  set_window(1023, 1023, 64, 32'hFFFF_FFFF);
				5:  set_window(0, 1023, 1, 1);
				6:  set_window(7, 3, 2, 1);                 // lower above upper
				7:  set_window(0, 20, 127, 1);              // too many substates
				8:  set_window(0, 31, 33, 1);               // span too large
				9:  set_window(0, 1, 2, 0);                 // zero sweep size
				default: begin
					subs = $urandom_range(1, 64);
					lo = $urandom_range(0, 1023);
					hi = lo + $urandom_range(0, MAX_MACROSTATES / subs - 1);
					if (hi > 1023) hi = 1023;
					set_window(lo, hi, subs, $urandom_range(1, 3));
				end
			endcase
			repeat ((ph == 2) ? 2 * PHASE_ITEMS : PHASE_ITEMS) random_command();
		end

		// all stimulus in; let the tail drain
		drain();
		repeat (50) @(posedge clk);
		$display("covered %0d accepted records, %0d rejected moves, %0d clears, %0d full sweeps",
			n_records, n_rejects, n_clears, n_full);
		$display("windows from a single state up to the full table, invalid setups included");
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire

@@ sim.f @@
rtl/core/tmmc_pkg.sv
rtl/core/tmmc_ifs.sv
rtl/core/tmmc_front.sv
rtl/core/tmmc_queue.sv
rtl/core/tmmc_back.sv
rtl/core/tmmc_collection_matrix_engine_unit.sv
rtl/core/tmmc_checker.sv
tb/tmmc_collection_matrix_engine_unit_tb.sv
